[src/yuv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// yuv2rgb_pkg
// Shared widths, coefficient reset values, register indexes and lane types
// for the YUYV to RGB converter.
// ----------------------------------------------------------------------------
package yuv2rgb_pkg;

  localparam int unsigned PIX_W   = 8;   // one sample or one color channel
  localparam int unsigned COEF_W  = 12;  // coefficient, value times 1000
  localparam int unsigned OFS_W   = 9;   // signed sample minus its offset
  localparam int unsigned PROD_W  = COEF_W + 1 + OFS_W;  // signed product
  localparam int unsigned SUM_W   = 24;  // signed channel sum before scaling
  localparam int unsigned FRAC_W  = 18;  // in-range sums are below 2^18
  localparam int unsigned RCP_W   = 19;
  localparam int unsigned MUL_W   = FRAC_W + RCP_W;
  localparam int unsigned RCP_SH  = 28;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned NUM_CH  = 6;   // R, G, B of two pixels

  localparam logic signed [OFS_W-1:0] LUMA_OFS   = 9'sd16;
  localparam logic signed [OFS_W-1:0] CHROMA_OFS = 9'sd128;

  // floor(x / 1000) == (x * 268436) >> 28 for every x below 2^18
  localparam logic [RCP_W-1:0]        RECIP      = 19'd268436;
  localparam logic signed [SUM_W-1:0] CLAMP_LIM  = 24'sd256000;
  localparam logic [PIX_W-1:0]        CHAN_MAX   = 8'd255;

  localparam logic [COEF_W-1:0] LUMA_GAIN_RST     = 12'd1164;
  localparam logic [COEF_W-1:0] RED_FROM_CR_RST   = 12'd1159;
  localparam logic [COEF_W-1:0] GREEN_FROM_CB_RST = 12'd380;
  localparam logic [COEF_W-1:0] GREEN_FROM_CR_RST = 12'd813;
  localparam logic [COEF_W-1:0] BLUE_FROM_CB_RST  = 12'd2018;

  typedef enum logic [CFG_AW-1:0] {
    REG_LUMA_GAIN     = 3'd0,
    REG_RED_FROM_CR   = 3'd1,
    REG_GREEN_FROM_CB = 3'd2,
    REG_GREEN_FROM_CR = 3'd3,
    REG_BLUE_FROM_CB  = 3'd4
  } cfg_reg_t;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // stage enables of one scale-and-clamp lane
  typedef struct packed {
    logic mul;  // load reciprocal product and range flags
    logic res;  // load clamped channel value
  } chan_adv_t;

endpackage

[src/yuv2rgb_luma_lane.sv]
// ----------------------------------------------------------------------------
// yuv2rgb_luma_lane
// Luma product of one pixel: luma_gain * (Y - 16), registered.
// ----------------------------------------------------------------------------
module yuv2rgb_luma_lane (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [yuv2rgb_pkg::PIX_W-1:0]  y,
  input  logic [yuv2rgb_pkg::COEF_W-1:0] gain,
  output yuv2rgb_pkg::prod_t          lum
);
  import yuv2rgb_pkg::*;

  logic signed [OFS_W-1:0]  y_ofs;
  logic signed [COEF_W:0]   gain_s;
  prod_t                    lum_r;
  prod_t                    lum_nxt;

  assign y_ofs   = $signed({1'b0, y}) - LUMA_OFS;
  assign gain_s  = $signed({1'b0, gain});
  assign lum_nxt = gain_s * y_ofs;

  always_ff @(posedge clk) begin
    if (adv) begin
      lum_r <= lum_nxt;
    end
  end

  assign lum = lum_r;

endmodule

[src/yuv2rgb_chroma.sv]
// ----------------------------------------------------------------------------
// yuv2rgb_chroma
// Chroma products shared by both pixels of a group, registered.
// ----------------------------------------------------------------------------
module yuv2rgb_chroma (
  input  logic                           clk,
  input  logic                           adv,
  input  logic [yuv2rgb_pkg::PIX_W-1:0]  cb,
  input  logic [yuv2rgb_pkg::PIX_W-1:0]  cr,
  input  logic [yuv2rgb_pkg::COEF_W-1:0] red_from_cr,
  input  logic [yuv2rgb_pkg::COEF_W-1:0] green_from_cb,
  input  logic [yuv2rgb_pkg::COEF_W-1:0] green_from_cr,
  input  logic [yuv2rgb_pkg::COEF_W-1:0] blue_from_cb,
  output yuv2rgb_pkg::prod_t             r_term,
  output yuv2rgb_pkg::prod_t             g_cb_term,
  output yuv2rgb_pkg::prod_t             g_cr_term,
  output yuv2rgb_pkg::prod_t             b_term
);
  import yuv2rgb_pkg::*;

  logic signed [OFS_W-1:0] cb_ofs;
  logic signed [OFS_W-1:0] cr_ofs;
  prod_t r_r, gb_r, gr_r, b_r;

  assign cb_ofs = $signed({1'b0, cb}) - CHROMA_OFS;
  assign cr_ofs = $signed({1'b0, cr}) - CHROMA_OFS;

  always_ff @(posedge clk) begin
    if (adv) begin
      r_r  <= $signed({1'b0, red_from_cr})   * cr_ofs;
      gb_r <= $signed({1'b0, green_from_cb}) * cb_ofs;
      gr_r <= $signed({1'b0, green_from_cr}) * cr_ofs;
      b_r  <= $signed({1'b0, blue_from_cb})  * cb_ofs;
    end
  end

  assign r_term    = r_r;
  assign g_cb_term = gb_r;
  assign g_cr_term = gr_r;
  assign b_term    = b_r;

endmodule

[src/yuv2rgb_chan.sv]
// ----------------------------------------------------------------------------
// yuv2rgb_chan
// Scale one channel sum by 1/1000 toward zero and clamp to 0..255.
// Negative sums give 0; sums of 256000 and more give 255; the rest go
// through a reciprocal multiply.
// ----------------------------------------------------------------------------
module yuv2rgb_chan (
  input  logic                          clk,
  input  yuv2rgb_pkg::chan_adv_t        adv,
  input  yuv2rgb_pkg::sum_t             sum,
  output logic [yuv2rgb_pkg::PIX_W-1:0] chan
);
  import yuv2rgb_pkg::*;

  logic [MUL_W-1:0] prod_r;
  logic             neg_r;
  logic             over_r;
  logic [PIX_W-1:0] chan_r;
  logic [PIX_W-1:0] chan_nxt;

  always_ff @(posedge clk) begin
    if (adv.mul) begin
      prod_r <= MUL_W'(sum[FRAC_W-1:0]) * MUL_W'(RECIP);
      neg_r  <= sum[SUM_W-1];
      over_r <= (sum >= CLAMP_LIM);
    end
  end

  always_comb begin
    priority if (neg_r) begin
      chan_nxt = '0;
    end else if (over_r) begin
      chan_nxt = CHAN_MAX;
    end else begin
      chan_nxt = prod_r[RCP_SH +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.res) begin
      chan_r <= chan_nxt;
    end
  end

  assign chan = chan_r;

endmodule

[src/yuyv_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter
// YUYV 4:2:2 group in, two RGB pixels out, with programmable coefficients.
// ----------------------------------------------------------------------------
// Datapath: each beat passes the products, channel sums, reciprocal multiply
//   and clamp registers, in that order.
// Throughput: one beat per cycle while the output is not stalled; each stage
//   stalls only when full and its successor cannot take it; bubbles are filled.
// Reset: rst_n synchronous, active low; clears all stage valids and loads
//   the coefficient registers with their default values.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_converter (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // y_first, cb_sample, y_second, cr_sample
  input  logic        in_tlast,   // frame_end
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // red_first, green_first, blue_first,
                                  // red_second, green_second, blue_second
  output logic        out_tlast,  // frame_end_out
  // coefficient write port
  input  logic                           cfg_we,
  input  logic [yuv2rgb_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [yuv2rgb_pkg::COEF_W-1:0] cfg_wdata
);
  import yuv2rgb_pkg::*;

  // --------------------------------------------------------------------------
  // Coefficient registers
  // --------------------------------------------------------------------------
  logic [COEF_W-1:0] luma_gain_r, red_from_cr_r, green_from_cb_r;
  logic [COEF_W-1:0] green_from_cr_r, blue_from_cb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      luma_gain_r     <= LUMA_GAIN_RST;
      red_from_cr_r   <= RED_FROM_CR_RST;
      green_from_cb_r <= GREEN_FROM_CB_RST;
      green_from_cr_r <= GREEN_FROM_CR_RST;
      blue_from_cb_r  <= BLUE_FROM_CB_RST;
    end else if (cfg_we) begin
      // drop writes to unused indexes
      unique case (cfg_addr)
        REG_LUMA_GAIN:     luma_gain_r     <= cfg_wdata;
        REG_RED_FROM_CR:   red_from_cr_r   <= cfg_wdata;
        REG_GREEN_FROM_CB: green_from_cb_r <= cfg_wdata;
        REG_GREEN_FROM_CR: green_from_cr_r <= cfg_wdata;
        REG_BLUE_FROM_CB:  blue_from_cb_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: stage 1 products, stage 2 sums, stage 3 reciprocal
  // product, stage 4 output register. A stage advances when it is empty or
  // the next stage advances.
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r;
  logic l1_r, l2_r, l3_r, l4_r;
  logic adv1, adv2, adv3, adv4;
  logic in_acc;

  assign adv4   = !v4_r || out_tready;
  assign adv3   = !v3_r || adv4;
  assign adv2   = !v2_r || adv3;
  assign adv1   = !v1_r || adv2;
  assign in_acc = in_tvalid && adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_tvalid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  // frame-end flag rides along with the data
  always_ff @(posedge clk) begin
    if (adv1) l1_r <= in_tlast;
    if (adv2) l2_r <= l1_r;
    if (adv3) l3_r <= l2_r;
    if (adv4) l4_r <= l3_r;
  end

  // --------------------------------------------------------------------------
  // Stage 1: two luma lanes and the shared chroma products
  // --------------------------------------------------------------------------
  prod_t lum0, lum1, r_term, g_cb_term, g_cr_term, b_term;

  yuv2rgb_luma_lane u_luma0 (
    .clk  (clk),
    .adv  (adv1),
    .y    (in_tdata[7:0]),
    .gain (luma_gain_r),
    .lum  (lum0)
  );

  yuv2rgb_luma_lane u_luma1 (
    .clk  (clk),
    .adv  (adv1),
    .y    (in_tdata[23:16]),
    .gain (luma_gain_r),
    .lum  (lum1)
  );

  yuv2rgb_chroma u_chroma (
    .clk           (clk),
    .adv           (adv1),
    .cb            (in_tdata[15:8]),
    .cr            (in_tdata[31:24]),
    .red_from_cr   (red_from_cr_r),
    .green_from_cb (green_from_cb_r),
    .green_from_cr (green_from_cr_r),
    .blue_from_cb  (blue_from_cb_r),
    .r_term        (r_term),
    .g_cb_term     (g_cb_term),
    .g_cr_term     (g_cr_term),
    .b_term        (b_term)
  );

  // --------------------------------------------------------------------------
  // Stage 2: merge luma and chroma terms into six channel sums
  // --------------------------------------------------------------------------
  sum_t lum0_x, lum1_x, r_x, gb_x, gr_x, b_x;
  sum_t sum_r [NUM_CH];

  assign lum0_x = SUM_W'(lum0);
  assign lum1_x = SUM_W'(lum1);
  assign r_x    = SUM_W'(r_term);
  assign gb_x   = SUM_W'(g_cb_term);
  assign gr_x   = SUM_W'(g_cr_term);
  assign b_x    = SUM_W'(b_term);

  always_ff @(posedge clk) begin
    if (adv2) begin
      sum_r[0] <= lum0_x + r_x;
      sum_r[1] <= lum0_x - gb_x - gr_x;
      sum_r[2] <= lum0_x + b_x;
      sum_r[3] <= lum1_x + r_x;
      sum_r[4] <= lum1_x - gb_x - gr_x;
      sum_r[5] <= lum1_x + b_x;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 3 and 4: one scale-and-clamp lane per channel
  // --------------------------------------------------------------------------
  chan_adv_t chan_adv;

  assign chan_adv.mul = adv3;
  assign chan_adv.res = adv4;

  for (genvar i = 0; i < NUM_CH; i++) begin : g_chan
    yuv2rgb_chan u_chan (
      .clk  (clk),
      .adv  (chan_adv),
      .sum  (sum_r[i]),
      .chan (out_tdata[i*PIX_W +: PIX_W])
    );
  end

  assign in_tready  = adv1;
  assign out_tvalid = v4_r;
  assign out_tlast  = l4_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // input may only be held off when the output is stalled
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without an output stall");

  // a full pipeline behind a stalled output must refuse input
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted into a full pipeline");

  // a new output beat must come from a filled stage 3
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(v3_r))
    else $error("output valid without a source beat");

  // an accepted beat occupies stage 1 in the next cycle
  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> v1_r)
    else $error("accepted beat lost at stage 1");

endmodule
